// File: rtl/erng_pkg.sv
`timescale 1ns / 1ps
package erng_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned POOL_DEPTH  = 16;
  localparam int unsigned IDX_W       = $clog2(POOL_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] SEED_RESET = 32'h0000_ACE1;
  localparam logic [WORD_W-1:0] POOL_BASE  = 32'h5A5A_5A5A;
  localparam logic [WORD_W-1:0] POOL_STEP  = 32'h1357_9BDF;
  localparam logic [3:0]        DRAW_MASK  = 4'd15;
  localparam logic [3:0]        POS_MASK   = 4'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_MIX   = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // one queued operation: optional draw, then optional mix of word
  typedef struct packed {
    logic              draw;
    logic              mix;
    logic [WORD_W-1:0] word;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [WORD_W-1:0] pool_init(input int unsigned i);
    logic [WORD_W-1:0] prod;
    prod = WORD_W'(i * POOL_STEP);
    return POOL_BASE ^ prod;
  endfunction

  // right shift, feedback from bits 0, 2, 3, 5 into the top bit
  function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] r);
    logic fb;
    fb = r[0] ^ r[2] ^ r[3] ^ r[5];
    return {fb, r[WORD_W-1:1]};
  endfunction

endpackage

// File: rtl/erng_if.sv
`timescale 1ns / 1ps
interface erng_in_if;
  import erng_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] data_word;
  logic [WORD_W-1:0] position;

  modport source (output valid, output cmd, output data_word, output position, input ready);
  modport sink   (input valid, input cmd, input data_word, input position, output ready);
endinterface

interface erng_out_if;
  import erng_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] random_byte;

  modport source (output valid, output random_byte, input ready);
  modport sink   (input valid, input random_byte, output ready);
endinterface

// File: rtl/erng_front.sv
`timescale 1ns / 1ps
module erng_front
  import erng_pkg::*;
(
  erng_in_if.sink in_ch,
  input  q_stat_t q_stat,
  output logic    push,
  output op_t     push_op
);

  logic take;

  assign in_ch.ready = !q_stat.full;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_op = '0;
    unique case (cmd_t'(in_ch.cmd))
      CMD_MIX: begin
        push_op.mix  = 1'b1;
        push_op.word = in_ch.data_word;
      end
      CMD_DRAW: begin
        push_op.draw = 1'b1;
        push_op.mix  = ((in_ch.position[3:0] & POS_MASK) == 4'd0);
        push_op.word = in_ch.data_word + in_ch.position;
      end
      CMD_WRITE: begin
        push_op.mix  = 1'b1;
        push_op.word = {in_ch.position[WORD_W-BYTE_W-1:0], in_ch.data_word[BYTE_W-1:0]};
      end
      default: begin
        push_op = '0;
      end
    endcase
  end

  // unused command is taken and dropped
  assign push = take && (push_op.draw || push_op.mix);

endmodule

// File: rtl/erng_fifo.sv
`timescale 1ns / 1ps
module erng_fifo
  import erng_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     head_op,
  output q_stat_t q_stat
);

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_op      = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: rtl/erng_back.sv
`timescale 1ns / 1ps
module erng_back
  import erng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  input  q_stat_t           q_stat,
  input  op_t               head_op,
  output logic              pop,
  erng_out_if.source        out_ch
);

  logic [WORD_W-1:0] sr_r, sr_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] pool_r [POOL_DEPTH];
  logic              out_valid_r;
  logic [BYTE_W-1:0] byte_r;

  logic [WORD_W-1:0] stepped;
  logic [WORD_W-1:0] drawn;
  logic [WORD_W-1:0] sr_mid;
  logic [IDX_W-1:0]  draw_idx;
  logic              can_out;

  assign can_out = !out_valid_r || out_ch.ready;
  assign pop     = !q_stat.empty && (!head_op.draw || can_out);

  always_comb begin
    stepped  = lfsr_step(sr_r);
    draw_idx = idx_r + IDX_W'(stepped[3:0] & DRAW_MASK);
    drawn    = stepped ^ pool_r[draw_idx];
    sr_mid   = head_op.draw ? drawn : sr_r;
    idx_nxt  = idx_r + IDX_W'(1);
    // the entry after the mixed one is untouched by this op, so old value is current
    sr_nxt   = head_op.mix ? (sr_mid ^ pool_r[idx_nxt]) : sr_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r        <= SEED_RESET;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int unsigned i = 0; i < POOL_DEPTH; i++) begin
        pool_r[i] <= pool_init(i);
      end
    end else begin
      if (cfg_we) begin
        sr_r <= cfg_wdata;
      end else if (pop) begin
        sr_r <= sr_nxt;
      end
      if (pop && head_op.mix) begin
        idx_r         <= idx_nxt;
        pool_r[idx_r] <= pool_r[idx_r] ^ head_op.word;
      end
      if (pop && head_op.draw) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.draw) begin
      byte_r <= drawn[BYTE_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_byte = byte_r;

endmodule

// File: rtl/entropy_pool_lfsr_rng.sv
`timescale 1ns / 1ps
// Random byte source: a 32-bit right-shifting LFSR mixed with a 16-word entropy
// pool. Commands are taken at one per clock into a two-entry queue unless it is
// full; the back end retires one queued command per clock, so sustained rate is
// one item per cycle; each draw's byte is registered. A draw only waits when its
// result register is still full and not being taken. Writing cfg_wdata loads the
// shift register at once; only write it while the block is idle.
module entropy_pool_lfsr_rng
  import erng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  erng_in_if.sink           in_ch,
  erng_out_if.source        out_ch
);

  q_stat_t q_stat;
  logic    push;
  op_t     push_op;
  logic    pop;
  op_t     head_op;

  erng_front u_front (
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .push    (push),
    .push_op (push_op)
  );

  erng_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .q_stat  (q_stat)
  );

  erng_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .head_op   (head_op),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // unused command never reaches the queue
  a_none_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_NONE) |-> !push)
    else $error("unused command queued");

  // a retired draw shows its byte next cycle
  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_op.draw) |=> out_ch.valid)
    else $error("draw without result");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !(pop && head_op.draw))
    else $error("result overwritten");

  // nothing retires from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import erng_pkg::*;

  localparam int DIR_N        = 23;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    cmd_t              op;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] pos;
    logic              known;
    logic [BYTE_W-1:0] val;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_wdata;

  erng_in_if  in_ch ();
  erng_out_if out_ch ();

  entropy_pool_lfsr_rng dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // own copy of the generator state
  logic [WORD_W-1:0] gen_sr;
  logic [WORD_W-1:0] pool_words [POOL_DEPTH];
  logic [3:0]        pool_ptr;

  logic [BYTE_W-1:0] pending_bytes [$];
  stim_row_t         dir_rows [DIR_N];

  bit jitter_on;
  bit calm;
  int fail_count;
  int bytes_checked;
  int items_sent;
  int n_draw;
  int n_mix;
  int n_write;
  int n_ignored;
  int seeds_loaded;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = ~clk;
  end

  function automatic void pool_reset();
    gen_sr = SEED_RESET;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_words[i] = POOL_BASE ^ WORD_W'(WORD_W'(i) * POOL_STEP);
    end
    pool_ptr = '0;
  endfunction

  function automatic void pool_absorb(input logic [WORD_W-1:0] w);
    logic [3:0] slot;
    slot = pool_ptr;
    pool_words[slot] ^= w;
    pool_ptr = slot + 4'd1;
    gen_sr ^= pool_words[pool_ptr];
  endfunction

  function automatic logic [BYTE_W-1:0] lfsr_draw();
    logic [WORD_W-1:0] r;
    logic              fb;
    logic [3:0]        sel;
    r   = gen_sr;
    fb  = r[0] ^ r[2] ^ r[3] ^ r[5];
    r   = {fb, r[WORD_W-1:1]};
    sel = pool_ptr + r[3:0];
    r   = r ^ pool_words[sel];
    gen_sr = r;
    return r[BYTE_W-1:0];
  endfunction

  function automatic void rng_predict(input cmd_t c, input logic [WORD_W-1:0] d,
                                      input logic [WORD_W-1:0] p, output bit has,
                                      output logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] sum;
    has = 1'b0;
    b   = '0;
    case (c)
      CMD_MIX: begin
        pool_absorb(d);
      end
      CMD_DRAW: begin
        b   = lfsr_draw();
        has = 1'b1;
        // every sixteenth position folds tick plus position back in
        if (p[3:0] == 4'd0) begin
          sum = d + p;
          pool_absorb(sum);
        end
      end
      CMD_WRITE: begin
        pool_absorb({24'h0, d[7:0]} | (p << 8));
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_item(input cmd_t c, input logic [WORD_W-1:0] d,
                           input logic [WORD_W-1:0] p, input bit known,
                           input logic [BYTE_W-1:0] known_val);
    bit                has;
    logic [BYTE_W-1:0] b;
    int                gap;
    @(negedge clk);
    if (jitter_on && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.data_word <= d;
    in_ch.position  <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rng_predict(c, d, p, has, b);
    if (has) pending_bytes.push_back(known ? known_val : b);
    case (c)
      CMD_MIX:   n_mix++;
      CMD_DRAW:  n_draw++;
      CMD_WRITE: n_write++;
      default:   n_ignored++;
    endcase
    if (c != CMD_NONE) items_sent++;
  endtask

  // drop valid and let the pipeline empty, mix-only work included
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(input logic [WORD_W-1:0] s);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gen_sr = s;
    seeds_loaded++;
  endtask

  function automatic logic [WORD_W-1:0] start_offset();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return $urandom & ~32'hF;
      2:       return 32'hFFFF_FFE0 + $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input int target);
    int                first;
    int                len;
    logic [WORD_W-1:0] tick;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] p;
    first = items_sent;
    while (items_sent - first < target) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // read: tick, buffer address and size mixed first, then the draws
          tick = $urandom;
          base = start_offset();
          len  = $urandom_range(1, 40);
          send_item(CMD_MIX, tick, $urandom, 1'b0, '0);
          send_item(CMD_MIX, $urandom, $urandom, 1'b0, '0);
          send_item(CMD_MIX, WORD_W'(len), $urandom, 1'b0, '0);
          for (int k = 0; k < len; k++) begin
            send_item(CMD_DRAW, tick, base + WORD_W'(k), 1'b0, '0);
          end
        end
        4, 5, 6: begin
          base = start_offset();
          len  = $urandom_range(1, 40);
          for (int k = 0; k < len; k++) begin
            send_item(CMD_WRITE, $urandom, base + WORD_W'(k), 1'b0, '0);
          end
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            p = ($urandom_range(0, 1) == 0) ? $urandom : ($urandom & ~32'hF);
            send_item(cmd_t'($urandom_range(0, 3)), $urandom, p, 1'b0, '0);
          end
        end
      endcase
    end
  endtask

  // result side: compare every transfer with the oldest expected byte
  always @(posedge clk) begin : byte_check
    logic [BYTE_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected byte %02h with nothing outstanding", out_ch.random_byte);
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_ch.random_byte !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("byte %0d: expected %02h, got %02h",
                     bytes_checked, want, out_ch.random_byte);
        end
      end
    end
  end

  // result side back-pressure
  initial begin : sink_stall
    int hold;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (jitter_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("entropy_pool_lfsr_rng verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [WORD_W-1:0] seeds [6];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_NONE;
    in_ch.data_word = '0;
    in_ch.position  = '0;
    jitter_on       = 1'b1;
    calm            = 1'b0;
    fail_count      = 0;
    bytes_checked   = 0;
    items_sent      = 0;
    n_draw          = 0;
    n_mix           = 0;
    n_write         = 0;
    n_ignored       = 0;
    seeds_loaded    = 0;
    pool_reset();

    // first draw after reset: seed steps to 0x5670, pool entry 0 xored in
    dir_rows = '{
      '{CMD_DRAW,  32'h0000_0000, 32'h0000_0001, 1'b1, 8'h2A},
      '{CMD_MIX,   32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
      '{CMD_DRAW,  32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_DRAW,  32'hFFFF_FFFF, 32'h0000_0010, 1'b0, 8'h00},
      '{CMD_DRAW,  32'h0000_0020, 32'hFFFF_FFF0, 1'b0, 8'h00},
      '{CMD_DRAW,  32'h1234_5678, 32'h0000_000F, 1'b0, 8'h00},
      '{CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
      '{CMD_WRITE, 32'hFFFF_FF00, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_WRITE, 32'h0000_00A5, 32'h00FF_FFFF, 1'b0, 8'h00},
      '{CMD_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
      '{CMD_NONE,  32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_DRAW,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
      '{CMD_DRAW,  32'h0000_0000, 32'h8000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'h8000_0000, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'h0000_0001, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'hA5A5_A5A5, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'h5A5A_5A5A, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'h0F0F_0F0F, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'hF0F0_F0F0, 32'h0000_0000, 1'b0, 8'h00},
      '{CMD_MIX,   32'h0000_FFFF, 32'h0000_0000, 1'b0, 8'h00},
      // pool index has wrapped by here
      '{CMD_DRAW,  32'h0000_0000, 32'h0000_0003, 1'b0, 8'h00},
      '{CMD_DRAW,  32'h0000_0007, 32'h0000_0020, 1'b0, 8'h00}
    };

    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hFFFF_FFFF;
    seeds[2] = $urandom;
    seeds[3] = 32'h8000_0000;
    seeds[4] = 32'h0000_0001;
    seeds[5] = $urandom;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_rows[i].op, dir_rows[i].word, dir_rows[i].pos,
                dir_rows[i].known, dir_rows[i].val);
    end

    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      load_seed(seeds[ph]);
      // final phase runs flat out on both sides
      if (ph == 5) begin
        jitter_on = 1'b0;
        calm      = 1'b1;
      end
      run_phase(PHASE_ITEMS);
    end

    quiesce();
    if (pending_bytes.size() != 0) begin
      fail_count++;
      $display("%0d expected bytes never arrived", pending_bytes.size());
    end
    $display("%0d commands sent: %0d mixes, %0d draws, %0d written bytes, %0d unused",
             items_sent + n_ignored, n_mix, n_draw, n_write, n_ignored);
    $display("%0d random bytes compared over %0d seed loads, %0d failures",
             bytes_checked, seeds_loaded, fail_count);
    if (fail_count == 0) begin
      $display("entropy_pool_lfsr_rng verification clean");
    end else begin
      $display("entropy_pool_lfsr_rng verification failed");
    end
    $finish;
  end

endmodule

// File: entropy_pool_lfsr_rng.f
rtl/erng_pkg.sv
rtl/erng_if.sv
rtl/erng_front.sv
rtl/erng_fifo.sv
rtl/erng_back.sv
rtl/entropy_pool_lfsr_rng.sv
sim/tb_top.sv
